/* hdl/ncrs_pkg.sv */
// ----------------------------------------------------------------------------
// ncrs_pkg
// Shared types and rotation tables for the cube rotation snap block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncrs_pkg;

   localparam int ROT_COUNT = 24;
   localparam int ID_WIDTH  = 5;
   localparam int ELEM_COUNT = 9;

   typedef logic [ID_WIDTH-1:0] rot_id_type;
   typedef logic [1:0]          col_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
   } merge_ctl_type;

   // The column of the nonzero entry in each row of each rotation.
   localparam col_type ROT_COL [ROT_COUNT][3] = '{
      '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2},
      '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd0, 2'd1, 2'd2},
      '{2'd1, 2'd2, 2'd0}, '{2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1},
      '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2}, '{2'd1, 2'd0, 2'd2},
      '{2'd2, 2'd0, 2'd1}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd0, 2'd1}
   };

   // Set where the nonzero entry of a row is minus one.
   localparam logic ROT_NEG [ROT_COUNT][3] = '{
      '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b1},
      '{1'b1, 1'b0, 1'b1}, '{1'b1, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1},
      '{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b1}, '{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0},
      '{1'b1, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0},
      '{1'b1, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b0}
   };

endpackage

`default_nettype wire

/* hdl/nearest_cube_rotation_snap.sv */
// ----------------------------------------------------------------------------
// nearest_cube_rotation_snap
// Snaps a 3x3 fixed-point matrix to the id of the nearest cube rotation.
// ----------------------------------------------------------------------------
// The request channel carries one word per matrix: nine signed elements in
// row-major order, taken when req_valid and req_ready are both high. The
// response channel returns one word per matrix, the rotation id 0 to 23,
// in request order.
// Twenty-four lanes score all rotations at once, and a two-stage maximum
// tree picks the winner, the lower id on a tie. Lane scores, then the tree
// stages, are registered; a new matrix is taken every cycle unless stalled.
// Each pipeline stage holds one word and moves on whenever the stage after
// it is empty or moving, so a stalled receiver fills the three stages
// before req_ready falls, and bubbles are squeezed out.
// A synchronous reset empties the pipeline; the score and id registers are
// not reset, and there is no configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_cube_rotation_snap #(
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r0c0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r0c1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r0c2,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r1c0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r1c1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r1c2,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r2c0,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r2c1,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m_r2c2,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ncrs_pkg::rot_id_type            rsp_orientation_id
);
   import ncrs_pkg::*;

   localparam int SCORE_WIDTH = ELEMENT_WIDTH + 2;

   logic signed [ELEMENT_WIDTH-1:0] elem [ELEM_COUNT];
   logic signed [SCORE_WIDTH-1:0]   score [ROT_COUNT];

   logic          s1_valid_ff, s1_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          s3_valid_ff, s3_valid_in;
   logic          adv1, adv2, adv3;
   merge_ctl_type merge_ctl;

   assign elem[0] = req_m_r0c0;
   assign elem[1] = req_m_r0c1;
   assign elem[2] = req_m_r0c2;
   assign elem[3] = req_m_r1c0;
   assign elem[4] = req_m_r1c1;
   assign elem[5] = req_m_r1c2;
   assign elem[6] = req_m_r2c0;
   assign elem[7] = req_m_r2c1;
   assign elem[8] = req_m_r2c2;

   assign adv3 = !s3_valid_ff || rsp_ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_ready = adv1;

   assign s1_valid_in = adv1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;

   assign merge_ctl.load_a = adv2 && s1_valid_ff;
   assign merge_ctl.load_b = adv3 && s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   for (genvar g = 0; g < ROT_COUNT; g++) begin : g_lane
      ncrs_lane #(
         .ELEMENT_WIDTH (ELEMENT_WIDTH),
         .LANE_ID       (g)
      ) u_lane (
         .clock    (clock),
         .load     (req_valid && adv1),
         .m        (elem),
         .score_ff (score[g])
      );
   end

   ncrs_merge #(
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_merge (
      .clock (clock),
      .ctl   (merge_ctl),
      .score (score),
      .id_ff (rsp_orientation_id)
   );

   assign rsp_valid = s3_valid_ff;

endmodule

`default_nettype wire

/* hdl/ncrs_lane.sv */
// ----------------------------------------------------------------------------
// ncrs_lane
// Scores one cube rotation: a registered signed sum of three elements.
// ----------------------------------------------------------------------------
`default_nettype none

module ncrs_lane #(
   parameter int ELEMENT_WIDTH = 16,
   parameter int LANE_ID       = 0
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [ELEMENT_WIDTH-1:0] m [ncrs_pkg::ELEM_COUNT],
   output logic signed [ELEMENT_WIDTH+1:0] score_ff
);
   import ncrs_pkg::*;

   localparam int SW = ELEMENT_WIDTH + 2;

   logic signed [SW-1:0] term [3];
   logic signed [SW-1:0] score_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         term[r] = SW'(m[r * 3 + int'(ROT_COL[LANE_ID][r])]);
         if (ROT_NEG[LANE_ID][r]) begin
            term[r] = -term[r];
         end
      end
      score_in = term[0] + term[1] + term[2];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         score_ff <= score_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ncrs_merge.sv */
// ----------------------------------------------------------------------------
// ncrs_merge
// Two-stage registered maximum tree over the lane scores; ties keep the
// lower rotation id.
// ----------------------------------------------------------------------------
`default_nettype none

module ncrs_merge #(
   parameter int SCORE_WIDTH = 18
) (
   input  logic                        clock,
   input  ncrs_pkg::merge_ctl_type     ctl,
   input  logic signed [SCORE_WIDTH-1:0] score [ncrs_pkg::ROT_COUNT],
   output ncrs_pkg::rot_id_type        id_ff
);
   import ncrs_pkg::*;

   logic signed [SCORE_WIDTH-1:0] l1_score [12];
   rot_id_type                    l1_id    [12];
   logic signed [SCORE_WIDTH-1:0] a_score_in [6];
   rot_id_type                    a_id_in    [6];
   logic signed [SCORE_WIDTH-1:0] a_score_ff [6];
   rot_id_type                    a_id_ff    [6];

   logic signed [SCORE_WIDTH-1:0] b1_score [3];
   rot_id_type                    b1_id    [3];
   logic signed [SCORE_WIDTH-1:0] b2_score;
   rot_id_type                    b2_id;
   rot_id_type                    id_in;

   // The left operand always carries the lower id, so it wins on a tie.
   always_comb begin
      for (int i = 0; i < 12; i++) begin
         if (score[2 * i + 1] > score[2 * i]) begin
            l1_score[i] = score[2 * i + 1];
            l1_id[i]    = ID_WIDTH'(2 * i + 1);
         end else begin
            l1_score[i] = score[2 * i];
            l1_id[i]    = ID_WIDTH'(2 * i);
         end
      end
      for (int i = 0; i < 6; i++) begin
         if (l1_score[2 * i + 1] > l1_score[2 * i]) begin
            a_score_in[i] = l1_score[2 * i + 1];
            a_id_in[i]    = l1_id[2 * i + 1];
         end else begin
            a_score_in[i] = l1_score[2 * i];
            a_id_in[i]    = l1_id[2 * i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         a_score_ff <= a_score_in;
         a_id_ff    <= a_id_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (a_score_ff[2 * i + 1] > a_score_ff[2 * i]) begin
            b1_score[i] = a_score_ff[2 * i + 1];
            b1_id[i]    = a_id_ff[2 * i + 1];
         end else begin
            b1_score[i] = a_score_ff[2 * i];
            b1_id[i]    = a_id_ff[2 * i];
         end
      end
      if (b1_score[1] > b1_score[0]) begin
         b2_score = b1_score[1];
         b2_id    = b1_id[1];
      end else begin
         b2_score = b1_score[0];
         b2_id    = b1_id[0];
      end
      if (b1_score[2] > b2_score) begin
         id_in = b1_id[2];
      end else begin
         id_in = b2_id;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_b) begin
         id_ff <= id_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ncrs_checker.sv */
// ----------------------------------------------------------------------------
// ncrs_checker
// Port-level checks for the cube rotation snap block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ncrs_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ncrs_pkg::rot_id_type rsp_orientation_id
);
   import ncrs_pkg::*;

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word present after reset");

   // Every reported id names one of the rotations.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_orientation_id < ID_WIDTH'(ROT_COUNT)))
      else $error("rotation id out of range");

   // A waiting response word holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_orientation_id))
      else $error("response word changed while stalled");

   // An accepted word reaches the output while the receiver keeps taking words.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("accepted word did not reach the output in time");

endmodule

bind nearest_cube_rotation_snap ncrs_checker u_ncrs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_orientation_id (rsp_orientation_id)
);

`default_nettype wire
